### src/ihf_pkg.sv
// Shared types and constants for the IPv4 receive header filter.
package ihf_pkg;

  localparam logic [15:0] HdrBytes   = 16'd20;
  localparam logic [15:0] CountMax   = 16'hFFFF;
  localparam logic [3:0]  IpVersion4 = 4'd4;
  localparam logic [3:0]  IhlNoOpts  = 4'd5;
  localparam logic [15:0] SumGood    = 16'hFFFF;

  // header byte offsets
  localparam logic [4:0] OffVerIhl = 5'd0;
  localparam logic [4:0] OffLenHi  = 5'd2;
  localparam logic [4:0] OffLenLo  = 5'd3;
  localparam logic [4:0] OffProto  = 5'd9;
  localparam logic [4:0] OffSrc0   = 5'd12;
  localparam logic [4:0] OffSrc3   = 5'd15;
  localparam logic [4:0] OffDst0   = 5'd16;
  localparam logic [4:0] OffDst3   = 5'd19;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  localparam logic [2:0] StatusAccepted = 3'd0;
  localparam logic [2:0] StatusShort    = 3'd1;
  localparam logic [2:0] StatusVersion  = 3'd2;
  localparam logic [2:0] StatusChecksum = 3'd3;
  localparam logic [2:0] StatusNotOurs  = 3'd4;
  localparam logic [2:0] StatusLength   = 3'd5;

  localparam logic [1:0] ClassIcmp  = 2'd0;
  localparam logic [1:0] ClassUdp   = 2'd1;
  localparam logic [1:0] ClassTcp   = 2'd2;
  localparam logic [1:0] ClassOther = 2'd3;

  // APB register index
  localparam logic RegLocalAddress = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  protocol_class;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [15:0] payload_length;
  } out_beat_t;

  // per-frame summary handed from front to back
  typedef struct packed {
    logic [15:0] received;
    logic [19:0] header_sum;
    logic [7:0]  ver_ihl;
    logic [15:0] tot_len;
    logic [7:0]  protocol;
    logic [31:0] source;
    logic [31:0] destination;
  } frame_t;

endpackage

### src/ihf_front.sv
// Front end: byte counting, header capture and checksum accumulation.
module ihf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_valid_i,
  input  logic              beat_accept_i,
  input  ihf_pkg::in_beat_t beat_i,
  output logic              push_o,
  output ihf_pkg::frame_t   frame_o
);

  logic [15:0] count_q, count_d;
  logic [19:0] sum_q, sum_d;
  logic [7:0]  hold_q, hold_d;
  logic [7:0]  ver_q, ver_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic        in_hdr;
  logic [4:0]  pos;
  logic [7:0]  b;

  assign in_hdr = (count_q < ihf_pkg::HdrBytes);
  assign pos    = count_q[4:0];
  assign b      = beat_i.data_byte;

  always_comb begin
    count_d = (count_q != ihf_pkg::CountMax) ? count_q + 16'd1 : count_q;
    sum_d   = sum_q;
    hold_d  = hold_q;
    ver_d   = ver_q;
    len_d   = len_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    if (in_hdr) begin
      if (!pos[0]) begin
        hold_d = b;
      end else begin
        sum_d = sum_q + {4'd0, hold_q, b};
      end
      if (pos == ihf_pkg::OffVerIhl) begin
        ver_d = b;
      end else if (pos == ihf_pkg::OffLenHi || pos == ihf_pkg::OffLenLo) begin
        len_d = {len_q[7:0], b};
      end else if (pos == ihf_pkg::OffProto) begin
        proto_d = b;
      end else if (pos >= ihf_pkg::OffSrc0 && pos <= ihf_pkg::OffSrc3) begin
        src_d = {src_q[23:0], b};
      end else if (pos >= ihf_pkg::OffDst0 && pos <= ihf_pkg::OffDst3) begin
        dst_d = {dst_q[23:0], b};
      end
    end
  end

  assign push_o = beat_valid_i && beat_accept_i && beat_i.last_byte;

  always_comb begin
    frame_o.received     = count_d;
    frame_o.header_sum   = sum_d;
    frame_o.ver_ihl      = ver_d;
    frame_o.tot_len      = len_d;
    frame_o.protocol     = proto_d;
    frame_o.source       = src_d;
    frame_o.destination  = dst_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      hold_q  <= '0;
      ver_q   <= '0;
      len_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
    end else if (beat_valid_i && beat_accept_i) begin
      if (beat_i.last_byte) begin
        // verdict taken: start the next frame clean
        count_q <= '0;
        sum_q   <= '0;
        hold_q  <= '0;
        ver_q   <= '0;
        len_q   <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
      end else begin
        count_q <= count_d;
        sum_q   <= sum_d;
        hold_q  <= hold_d;
        ver_q   <= ver_d;
        len_q   <= len_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
      end
    end
  end

endmodule

### src/ihf_queue.sv
// Short FIFO of frame summaries between front and back.
module ihf_queue #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ihf_pkg::frame_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output ihf_pkg::frame_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ihf_pkg::frame_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### src/ihf_back.sv
// Back end: verdict evaluation and registered result beat.
module ihf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  ihf_pkg::frame_t    head_i,
  input  logic [31:0]        local_address_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ihf_pkg::out_beat_t out_o
);

  logic               out_valid_q;
  ihf_pkg::out_beat_t out_q, out_d;
  logic [16:0]        fold1;
  logic [15:0]        fold2;

  // end-around carry fold: two steps suffice for a 20-bit sum
  assign fold1 = {1'b0, head_i.header_sum[15:0]} + {13'd0, head_i.header_sum[19:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  always_comb begin
    out_d = '0;
    if (head_i.received < ihf_pkg::HdrBytes) begin
      out_d.status = ihf_pkg::StatusShort;
    end else if (head_i.ver_ihl[7:4] != ihf_pkg::IpVersion4 ||
                 head_i.ver_ihl[3:0] != ihf_pkg::IhlNoOpts) begin
      out_d.status = ihf_pkg::StatusVersion;
    end else if (fold2 != ihf_pkg::SumGood) begin
      out_d.status = ihf_pkg::StatusChecksum;
    end else if (head_i.destination != local_address_i) begin
      out_d.status = ihf_pkg::StatusNotOurs;
    end else if (head_i.tot_len < ihf_pkg::HdrBytes ||
                 head_i.tot_len > head_i.received) begin
      out_d.status = ihf_pkg::StatusLength;
    end else begin
      out_d.status          = ihf_pkg::StatusAccepted;
      out_d.protocol_number = head_i.protocol;
      out_d.source_address  = head_i.source;
      out_d.payload_length  = head_i.tot_len - ihf_pkg::HdrBytes;
      case (head_i.protocol)
        ihf_pkg::ProtoIcmp: out_d.protocol_class = ihf_pkg::ClassIcmp;
        ihf_pkg::ProtoUdp:  out_d.protocol_class = ihf_pkg::ClassUdp;
        ihf_pkg::ProtoTcp:  out_d.protocol_class = ihf_pkg::ClassTcp;
        default:            out_d.protocol_class = ihf_pkg::ClassOther;
      endcase
    end
  end

  assign pop_o       = head_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

### src/ipv4_receive_header_filter.sv
// Top level: IPv4 receive header filter, one frame byte per input beat.
// Input: one byte per cycle, stalled only while the frame summary FIFO is full.
// Verdict path: the last byte's summary is written into the FIFO, then
//   evaluated in the registered verdict stage.
// Throughput: 1 byte per cycle while out_stall_i is low, even with one-byte frames.
// Reset (async, active low): byte count, header capture and FIFO cleared; local_address = 0.
module ipv4_receive_header_filter #(
  parameter int QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ihf_pkg::in_beat_t  in_i,
  // verdict output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ihf_pkg::out_beat_t out_o,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0]     local_addr_q;
  logic            q_full, q_empty, q_pop, q_push;
  ihf_pkg::frame_t front_frame, head_frame;

  // Single register: local_address at byte address 0. paddr[2] is the
  // register index; writes to the unused slot are dropped.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ihf_pkg::RegLocalAddress) ? local_addr_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ihf_pkg::RegLocalAddress) begin
      local_addr_q <= pwdata;
    end
  end

  // Input stalls only on FIFO full; the back drains one summary per cycle while not stalled.
  assign in_stall_o = q_full;

  ihf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_valid_i  (in_valid_i),
    .beat_accept_i (!q_full),
    .beat_i        (in_i),
    .push_o        (q_push),
    .frame_o       (front_frame)
  );

  ihf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_frame),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head_frame)
  );

  ihf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (!q_empty),
    .head_i          (head_frame),
    .local_address_i (local_addr_q),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_o           (out_o)
  );

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the IPv4 receive header filter.
module tb_top;

  localparam int MaxWait     = 17;
  localparam int CycleLimit  = 600000;
  localparam int RandomBytes = 760;
  localparam int DrainCycles = 6;   // FIFO write and verdict stage, plus margin
  localparam int OffCsumHi   = 10;
  localparam int OffCsumLo   = 11;
  localparam logic [2:0] AddrLocalAddress = {ihf_pkg::RegLocalAddress, 2'b00};
  localparam logic [7:0] VerIhlPlain      = {ihf_pkg::IpVersion4, ihf_pkg::IhlNoOpts};

  // kinds of random frame
  typedef enum int {
    FrmGood, FrmBadVersion, FrmCorrupt, FrmForeign, FrmBadLength, FrmShort, FrmNoise
  } frame_kind_e;

  typedef logic [7:0] byte_q_t[$];

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ihf_pkg::in_beat_t   in_beat = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ihf_pkg::out_beat_t  out_beat;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  ipv4_receive_header_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  int unsigned cycles = 0;
  int          errors = 0;
  bit          no_idle = 1'b0;   // both sides run without gaps while set

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Header filter model: frame state mirrored at the block's widths.
  // ---------------------------------------------------------------------------
  logic [31:0] host_addr = '0;   // mirror of local_address
  logic [15:0] rx_count = '0;
  logic [19:0] rx_sum = '0;
  logic [7:0]  rx_hi = '0;
  logic [7:0]  rx_ver_ihl = '0;
  logic [15:0] rx_total_len = '0;
  logic [7:0]  rx_proto = '0;
  logic [31:0] rx_src = '0;
  logic [31:0] rx_dst = '0;

  ihf_pkg::out_beat_t verdict_q[$];     // verdicts still owed by the block

  task automatic filter_byte(input ihf_pkg::in_beat_t b);
    logic [15:0]        pos;
    logic [19:0]        folded;
    ihf_pkg::out_beat_t v;
    pos = rx_count;
    if (pos < ihf_pkg::HdrBytes) begin
      // even offsets hold the high byte of a 16-bit word
      if (!pos[0]) rx_hi = b.data_byte;
      else rx_sum = rx_sum + {rx_hi, b.data_byte};
      if (pos[4:0] == ihf_pkg::OffVerIhl) rx_ver_ihl = b.data_byte;
      else if (pos[4:0] == ihf_pkg::OffLenHi || pos[4:0] == ihf_pkg::OffLenLo)
        rx_total_len = {rx_total_len[7:0], b.data_byte};
      else if (pos[4:0] == ihf_pkg::OffProto) rx_proto = b.data_byte;
      else if (pos[4:0] >= ihf_pkg::OffSrc0 && pos[4:0] <= ihf_pkg::OffSrc3)
        rx_src = {rx_src[23:0], b.data_byte};
      else if (pos[4:0] >= ihf_pkg::OffDst0 && pos[4:0] <= ihf_pkg::OffDst3)
        rx_dst = {rx_dst[23:0], b.data_byte};
    end
    if (rx_count != ihf_pkg::CountMax) rx_count = rx_count + 16'd1;   // saturates
    if (b.last_byte) begin
      v = '0;
      folded = rx_sum;
      while (folded[19:16] != 4'd0) folded = folded[15:0] + folded[19:16];
      if (rx_count < ihf_pkg::HdrBytes) v.status = ihf_pkg::StatusShort;
      else if (rx_ver_ihl[7:4] != ihf_pkg::IpVersion4 ||
               rx_ver_ihl[3:0] != ihf_pkg::IhlNoOpts)
        v.status = ihf_pkg::StatusVersion;
      else if (folded[15:0] != ihf_pkg::SumGood) v.status = ihf_pkg::StatusChecksum;
      else if (rx_dst != host_addr) v.status = ihf_pkg::StatusNotOurs;
      else if (rx_total_len < ihf_pkg::HdrBytes || rx_total_len > rx_count)
        v.status = ihf_pkg::StatusLength;
      else begin
        v.status          = ihf_pkg::StatusAccepted;
        v.protocol_number = rx_proto;
        v.source_address  = rx_src;
        v.payload_length  = rx_total_len - ihf_pkg::HdrBytes;
        case (rx_proto)
          ihf_pkg::ProtoIcmp: v.protocol_class = ihf_pkg::ClassIcmp;
          ihf_pkg::ProtoUdp:  v.protocol_class = ihf_pkg::ClassUdp;
          ihf_pkg::ProtoTcp:  v.protocol_class = ihf_pkg::ClassTcp;
          default:            v.protocol_class = ihf_pkg::ClassOther;
        endcase
      end
      verdict_q.push_back(v);
      // fresh frame state for the next frame
      rx_count = '0;
      rx_sum = '0;
      rx_hi = '0;
      rx_ver_ihl = '0;
      rx_total_len = '0;
      rx_proto = '0;
      rx_src = '0;
      rx_dst = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // Scoreboard: verdict beats are checked first, then the byte beat of the
  // same edge feeds the model; a verdict always trails its last byte.
  ihf_pkg::out_beat_t oldest;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict, expected none actual %h", $time, out_beat);
          errors++;
        end else begin
          oldest = verdict_q.pop_front();
          check_field("status", 32'(oldest.status), 32'(out_beat.status));
          check_field("protocol_class", 32'(oldest.protocol_class),
                      32'(out_beat.protocol_class));
          check_field("protocol_number", 32'(oldest.protocol_number),
                      32'(out_beat.protocol_number));
          check_field("source_address", oldest.source_address, out_beat.source_address);
          check_field("payload_length", 32'(oldest.payload_length),
                      32'(out_beat.payload_length));
        end
      end
      if (in_valid && in_stall === 1'b0) filter_byte(in_beat);
    end
  end

  // Verdict receiver: random stall before each beat, none in no_idle stretches.
  initial begin : verdict_sink
    int n;
    forever begin
      n = no_idle ? 0 : $urandom_range(MaxWait, 0);
      repeat (n) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
      end
      @(negedge clk_i);
      out_stall <= 1'b0;
      do @(posedge clk_i); while (out_valid !== 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Byte sender and frame builders
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] data, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(MaxWait, 0);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_beat  <= {data, last};
    do @(posedge clk_i); while (in_stall !== 1'b0);
  endtask

  // hdr goes out first, then body random bytes; last flag on the final beat
  task automatic send_frame(input byte_q_t hdr, input int body);
    int total;
    int i;
    total = hdr.size() + body;
    for (i = 0; i < total; i++)
      send_byte(i < hdr.size() ? hdr[i] : 8'($urandom), i == total - 1);
  endtask

  // 20-byte header with random filler and a valid checksum
  task automatic make_header(input logic [7:0] ver_ihl, input logic [15:0] tlen,
                             input logic [7:0] proto, input logic [31:0] src,
                             input logic [31:0] dst, output byte_q_t h);
    logic [31:0] sum;
    logic [15:0] csum;
    int i;
    h = {};
    for (i = 0; i < ihf_pkg::HdrBytes; i++) h.push_back(8'($urandom));
    h[ihf_pkg::OffVerIhl] = ver_ihl;
    h[ihf_pkg::OffLenHi]  = tlen[15:8];
    h[ihf_pkg::OffLenLo]  = tlen[7:0];
    h[ihf_pkg::OffProto]  = proto;
    h[OffCsumHi] = 8'h00;
    h[OffCsumLo] = 8'h00;
    for (i = 0; i < 4; i++) begin
      h[ihf_pkg::OffSrc0 + i] = src[31 - 8*i -: 8];
      h[ihf_pkg::OffDst0 + i] = dst[31 - 8*i -: 8];
    end
    sum = '0;
    for (i = 0; i < ihf_pkg::HdrBytes; i += 2) sum = sum + {h[i], h[i+1]};
    while (sum[31:16] != 16'd0) sum = sum[15:0] + sum[31:16];
    csum = ~sum[15:0];
    h[OffCsumHi] = csum[15:8];
    h[OffCsumLo] = csum[7:0];
  endtask

  task automatic send_packet(input logic [7:0] ver_ihl, input logic [15:0] tlen,
                             input logic [7:0] proto, input logic [31:0] src,
                             input logic [31:0] dst, input int body);
    byte_q_t h;
    make_header(ver_ihl, tlen, proto, src, dst, h);
    send_frame(h, body);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  // Stop sending and let every owed verdict come out, plus the latency tail.
  task automatic drain();
    idle_input();
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrLocalAddress;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_local_address();
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    check_field("local_address readback", host_addr, rd);
  endtask

  // Register writes happen only with the block idle.
  task automatic set_local_address(input logic [31:0] addr);
    logic [31:0] rd;
    drain();
    apb_access(1'b1, addr, rd);
    host_addr = addr;
    check_local_address();
  endtask

  task automatic random_frame(output int nbytes);
    frame_kind_e kind;
    int          body;
    int          r;
    int          idx;
    logic [7:0]  ver_ihl;
    logic [15:0] tlen;
    logic [7:0]  proto;
    logic [31:0] dst;
    byte_q_t     h;
    r = $urandom_range(11, 0);
    // half the frames well-formed, with random content
    kind = r < 6 ? FrmGood : frame_kind_e'(r - 5);
    body = $urandom_range(12, 0);
    if ($urandom_range(15, 0) == 0) body = $urandom_range(300, 13);
    tlen = ihf_pkg::HdrBytes + 16'($urandom_range(body, 0));
    case ($urandom_range(3, 0))
      0:       proto = ihf_pkg::ProtoIcmp;
      1:       proto = ihf_pkg::ProtoUdp;
      2:       proto = ihf_pkg::ProtoTcp;
      default: proto = 8'($urandom);
    endcase
    ver_ihl = VerIhlPlain;
    dst = host_addr;
    case (kind)
      FrmBadVersion: begin
        case ($urandom_range(2, 0))
          0:       ver_ihl = {ihf_pkg::IpVersion4, 4'($urandom)};
          1:       ver_ihl = {4'($urandom), ihf_pkg::IhlNoOpts};
          default: ver_ihl = 8'($urandom);
        endcase
        if (ver_ihl == VerIhlPlain) ver_ihl = ver_ihl ^ 8'h01;
      end
      FrmForeign: begin
        dst = $urandom;
        if (dst == host_addr) dst = ~dst;
      end
      FrmBadLength: begin
        case ($urandom_range(2, 0))
          0:       tlen = 16'($urandom_range(19, 0));
          1:       tlen = ihf_pkg::HdrBytes + 16'(body + 1 + $urandom_range(40, 0));
          default: tlen = 16'($urandom);
        endcase
      end
      default: ;
    endcase
    make_header(ver_ihl, tlen, proto, $urandom, dst, h);
    if (kind == FrmCorrupt) begin
      idx = $urandom_range(19, 0);
      h[idx] = h[idx] ^ 8'($urandom_range(255, 1));
    end
    if (kind == FrmShort || kind == FrmNoise) begin
      h = {};
      r = kind == FrmShort ? $urandom_range(19, 1) : $urandom_range(40, 1);
      repeat (r) h.push_back(8'($urandom));
      body = 0;
    end
    nbytes = h.size() + body;
    send_frame(h, body);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // local_address comes out of reset as zero: read it and hit it with a frame.
  task automatic test_reset_value();
    check_local_address();
    send_packet(VerIhlPlain, 16'd24, ihf_pkg::ProtoTcp, 32'h0A00_0001, 32'h0, 4);
    drain();
  endtask

  // Field extremes, each protocol class and each rejection reason.
  task automatic test_directed();
    byte_q_t h;
    set_local_address(32'hC0A8_0001);
    h = {8'hFF};
    send_frame(h, 0);                             // one-byte frame
    h = {};
    repeat (19) h.push_back(8'h00);
    send_frame(h, 0);                             // one byte short of a header
    send_packet(VerIhlPlain, 16'd20, ihf_pkg::ProtoIcmp, 32'hFFFF_FFFF, host_addr, 0);
    send_packet(VerIhlPlain, 16'd28, ihf_pkg::ProtoUdp, 32'h0000_0000, host_addr, 8);
    send_packet(VerIhlPlain, 16'd25, ihf_pkg::ProtoTcp, 32'h1234_5678, host_addr, 5);
    send_packet(VerIhlPlain, 16'd21, 8'hFF, 32'h8000_0001, host_addr, 3);
    send_packet(VerIhlPlain, 16'd20, 8'h00, 32'h7FFF_FFFE, host_addr, 0);
    send_packet({4'd6, ihf_pkg::IhlNoOpts}, 16'd20, ihf_pkg::ProtoUdp, 32'h1,
                host_addr, 0);
    send_packet({ihf_pkg::IpVersion4, 4'd6}, 16'd20, ihf_pkg::ProtoUdp, 32'h1,
                host_addr, 0);
    make_header(VerIhlPlain, 16'd20, ihf_pkg::ProtoTcp, 32'h2, host_addr, h);
    h[OffCsumLo] = h[OffCsumLo] ^ 8'h01;
    send_frame(h, 0);                             // checksum off by one bit
    send_packet(VerIhlPlain, 16'd20, ihf_pkg::ProtoTcp, 32'h3, ~host_addr, 0);
    send_packet(VerIhlPlain, 16'd19, ihf_pkg::ProtoTcp, 32'h4, host_addr, 2);
    send_packet(VerIhlPlain, 16'd0, ihf_pkg::ProtoTcp, 32'h4, host_addr, 0);
    // total length one past what was received
    send_packet(VerIhlPlain, 16'd27, ihf_pkg::ProtoTcp, 32'h5, host_addr, 6);
    set_local_address(32'hFFFF_FFFF);
    send_packet(VerIhlPlain, 16'd22, ihf_pkg::ProtoUdp, 32'hA5A5_5A5A, host_addr, 2);
    drain();
  endtask

  // Random traffic over several local addresses; each phase holds off once
  // until every owed verdict is out.
  task automatic test_random_traffic();
    logic [31:0] addrs[4];
    int p;
    int sent;
    int frames;
    int n;
    bit paused;
    addrs[0] = $urandom;
    addrs[1] = 32'h0000_0000;
    addrs[2] = 32'hFFFF_FFFF;
    addrs[3] = $urandom;
    for (p = 0; p < 4; p++) begin
      set_local_address(addrs[p]);
      sent = 0;
      frames = 0;
      paused = 1'b0;
      while (sent < RandomBytes / 4 || frames < 4) begin
        no_idle = $urandom_range(5, 0) == 0;   // occasional back-to-back burst
        random_frame(n);
        sent += n;
        frames++;
        if (!paused && sent >= RandomBytes / 8) begin
          no_idle = 1'b0;
          drain();
          paused = 1'b1;
        end
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_value();
    test_directed();
    test_random_traffic();
    drain();
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
